// ===== design/sal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sal_pkg
// Command and status codes, fixed field widths and the result word layout
// shared by the list engine modules.
// ----------------------------------------------------------------------------
package sal_pkg;

   localparam logic [3:0] CMD_CLEAR   = 4'd0;
   localparam logic [3:0] CMD_APPEND  = 4'd1;
   localparam logic [3:0] CMD_READ    = 4'd2;
   localparam logic [3:0] CMD_PERFECT = 4'd3;
   localparam logic [3:0] CMD_SECOND  = 4'd4;
   localparam logic [3:0] CMD_INSERT  = 4'd5;
   localparam logic [3:0] CMD_DELETE  = 4'd6;
   localparam logic [3:0] CMD_SORT    = 4'd7;
   localparam logic [3:0] CMD_SEARCH  = 4'd8;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOTFOUND = 3'd1;
   localparam logic [2:0] ST_BADPOS   = 3'd2;
   localparam logic [2:0] ST_UNDER2   = 3'd3;
   localparam logic [2:0] ST_NOSECOND = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   localparam logic signed [31:0] NONE_MARK = 32'sh7FFF_FFFF;

   // Trial division: positive 31-bit dividend, trial divisor up to sqrt(2^31).
   localparam int DVD_W = 31;
   localparam int DVS_W = 16;
   localparam int SUM_W = 40;

   typedef struct packed {
      logic [2:0]         status;
      logic [6:0]         count;
      logic [5:0]         index;
      logic signed [31:0] data;
   } rsp_word_type;

endpackage
`default_nettype wire

// ===== design/sal_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sal_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(DEPTH)-1:0] waddr,
   input  wire [WIDTH-1:0]         wdata,
   input  wire [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== design/sal_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sal_div
// Restoring divider, one quotient bit per cycle, used for the trial
// divisions of the perfect number test.
// ----------------------------------------------------------------------------
module sal_div (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire [sal_pkg::DVD_W-1:0]   dividend,
   input  wire [sal_pkg::DVS_W-1:0]   divisor,
   output logic                       done,
   output logic [sal_pkg::DVD_W-1:0]  quot,
   output logic [sal_pkg::DVS_W-1:0]  rem
);

   localparam int DVD_W = sal_pkg::DVD_W;
   localparam int DVS_W = sal_pkg::DVS_W;
   localparam int CW    = $clog2(DVD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DVD_W-1:0] quot_ff, quot_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W+1:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quot_ff[DVD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DVS_W+1]) begin
            rem_in  = diff[DVS_W-1:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DVS_W-1:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// ===== design/small_array_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// small_array_list_engine
// List of up to DEPTH signed 32-bit values driven by one command word at a
// time, run by a sequencer over one element RAM and one divider.
// ----------------------------------------------------------------------------
// Clear, append and error cases go straight to the output state; read out reads, uses
// and outputs each element in turn; search and second smallest read each element in
// turn; insert and delete move one element at a time; sort runs before its read out.
// Perfect count: per element above 1, one divider run per trial divisor, up to about
// sqrt(value) divisors.
// One command at a time (req_tready only while idle); reset clears the length.
module small_array_list_engine #(
   parameter int DEPTH = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // value[31:0], position[37:32], zero pad
   input  wire  [3:0]  req_tuser,   // cmd[3:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // data[31:0], index[37:32], count[44:38],
                                    // status[47:45]
   output logic        rsp_tlast
);

   localparam int LW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int DVD_W = sal_pkg::DVD_W;
   localparam int DVS_W = sal_pkg::DVS_W;
   localparam int SUM_W = sal_pkg::SUM_W;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_OUT   = 5'd1;
   localparam logic [4:0] S_ORD   = 5'd2;
   localparam logic [4:0] S_OUSE  = 5'd3;
   localparam logic [4:0] S_PRD   = 5'd4;
   localparam logic [4:0] S_PUSE  = 5'd5;
   localparam logic [4:0] S_PDIV  = 5'd6;
   localparam logic [4:0] S_MRD   = 5'd7;
   localparam logic [4:0] S_MUSE  = 5'd8;
   localparam logic [4:0] S_IRD   = 5'd9;
   localparam logic [4:0] S_IUSE  = 5'd10;
   localparam logic [4:0] S_DRD   = 5'd11;
   localparam logic [4:0] S_DUSE  = 5'd12;
   localparam logic [4:0] S_SRDI  = 5'd13;
   localparam logic [4:0] S_SUSEI = 5'd14;
   localparam logic [4:0] S_SRDJ  = 5'd15;
   localparam logic [4:0] S_SUSEJ = 5'd16;
   localparam logic [4:0] S_SWRI  = 5'd17;
   localparam logic [4:0] S_FRD   = 5'd18;
   localparam logic [4:0] S_FUSE  = 5'd19;

   logic [4:0]             state_ff, state_in;
   logic [LW-1:0]          idx_ff, idx_in;
   logic [LW-1:0]          jdx_ff, jdx_in;
   logic [LW-1:0]          len_ff, len_in;
   logic [LW-1:0]          cnt_ff, cnt_in;
   logic signed [31:0]     key_ff, key_in;
   logic signed [31:0]     cur_ff, cur_in;
   logic signed [31:0]     lo_ff, lo_in;
   logic signed [31:0]     sec_ff, sec_in;
   logic [DVD_W-1:0]       n_ff, n_in;
   logic [DVS_W-1:0]       dj_ff, dj_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   div_start_ff, div_start_in;
   sal_pkg::rsp_word_type  pend_ff, pend_in;
   logic                   pend_last_ff, pend_last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sal_pkg::rsp_word_type  rsp_word_ff, rsp_word_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   logic [31:0]            ram_wdata, ram_rdata;
   logic signed [31:0]     elem;
   logic                   div_done;
   logic [DVD_W-1:0]       div_quot;
   logic [DVS_W-1:0]       div_rem;

   logic [3:0]             in_cmd;
   logic signed [31:0]     in_value;
   logic [5:0]             in_pos;
   logic                   out_free;
   logic                   at_end;
   logic [LW-1:0]          cnt_next;
   logic signed [31:0]     lo_c, sec_c;

   assign in_cmd   = req_tuser;
   assign in_value = $signed(req_tdata[31:0]);
   assign in_pos   = req_tdata[37:32];
   assign elem     = $signed(ram_rdata);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign at_end   = (idx_ff + 1'b1) == len_ff;

   sal_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sal_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (n_ff),
      .divisor  (dj_ff),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      jdx_in       = jdx_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      lo_in        = lo_ff;
      sec_in       = sec_ff;
      n_in         = n_ff;
      dj_in        = dj_ff;
      sum_in       = sum_ff;
      div_start_in = 1'b0;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[AW-1:0];
      ram_wdata    = ram_rdata;
      ram_raddr    = idx_ff[AW-1:0];
      cnt_next     = cnt_ff;
      lo_c         = lo_ff;
      sec_c        = sec_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               pend_in.data   = '0;
               pend_in.index  = '0;
               pend_in.count  = 7'(len_ff);
               pend_in.status = sal_pkg::ST_OK;
               pend_last_in   = 1'b1;
               idx_in         = '0;
               unique case (in_cmd)
                  sal_pkg::CMD_CLEAR: begin
                     len_in        = '0;
                     pend_in.count = '0;
                     state_in      = S_OUT;
                  end
                  sal_pkg::CMD_APPEND: begin
                     if (len_ff >= LW'(DEPTH)) begin
                        pend_in.status = sal_pkg::ST_FULL;
                     end else begin
                        ram_we        = 1'b1;
                        ram_waddr     = len_ff[AW-1:0];
                        ram_wdata     = in_value;
                        len_in        = len_ff + 1'b1;
                        pend_in.count = 7'(len_ff + 1'b1);
                     end
                     state_in = S_OUT;
                  end
                  sal_pkg::CMD_READ: begin
                     state_in = (len_ff == '0) ? S_OUT : S_ORD;
                  end
                  sal_pkg::CMD_PERFECT: begin
                     cnt_in        = '0;
                     pend_in.count = '0;
                     state_in      = (len_ff == '0) ? S_OUT : S_PRD;
                  end
                  sal_pkg::CMD_SECOND: begin
                     if (len_ff < LW'(2)) begin
                        pend_in.status = sal_pkg::ST_UNDER2;
                        state_in       = S_OUT;
                     end else begin
                        state_in = S_MRD;
                     end
                  end
                  sal_pkg::CMD_INSERT: begin
                     if (len_ff >= LW'(DEPTH)) begin
                        pend_in.status = sal_pkg::ST_FULL;
                        state_in       = S_OUT;
                     end else begin
                        idx_in   = len_ff;
                        key_in   = in_value;
                        state_in = S_IRD;
                     end
                  end
                  sal_pkg::CMD_DELETE: begin
                     if (int'(in_pos) >= int'(len_ff)) begin
                        pend_in.status = sal_pkg::ST_BADPOS;
                        state_in       = S_OUT;
                     end else begin
                        idx_in   = LW'(in_pos);
                        state_in = S_DRD;
                     end
                  end
                  sal_pkg::CMD_SORT: begin
                     if (len_ff == '0) begin
                        state_in = S_OUT;
                     end else if (len_ff == LW'(1)) begin
                        state_in = S_ORD;
                     end else begin
                        state_in = S_SRDI;
                     end
                  end
                  sal_pkg::CMD_SEARCH: begin
                     key_in = in_value;
                     if (len_ff == '0) begin
                        pend_in.status = sal_pkg::ST_NOTFOUND;
                        state_in       = S_OUT;
                     end else begin
                        state_in = S_FRD;
                     end
                  end
                  default: begin
                     // Unknown commands are consumed without a result.
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = pend_ff;
               rsp_last_in  = pend_last_ff;
               if (pend_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         S_ORD: begin
            state_in = S_OUSE;
         end
         S_OUSE: begin
            pend_in.data   = elem;
            pend_in.index  = 6'(idx_ff);
            pend_in.count  = 7'(len_ff);
            pend_in.status = sal_pkg::ST_OK;
            pend_last_in   = at_end;
            state_in       = S_OUT;
         end
         S_PRD: begin
            state_in = S_PUSE;
         end
         S_PUSE: begin
            if (elem <= 32'sd1) begin
               if (at_end) begin
                  pend_in.count = 7'(cnt_ff);
                  state_in      = S_OUT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_PRD;
               end
            end else begin
               n_in         = elem[DVD_W-1:0];
               dj_in        = DVS_W'(2);
               sum_in       = SUM_W'(1);
               div_start_in = 1'b1;
               state_in     = S_PDIV;
            end
         end
         S_PDIV: begin
            if (div_done) begin
               if (div_quot < {{(DVD_W-DVS_W){1'b0}}, dj_ff}) begin
                  // Every divisor pair is in; compare the sum with the value.
                  cnt_next = cnt_ff + ((sum_ff == {{(SUM_W-DVD_W){1'b0}}, n_ff}) ?
                                       LW'(1) : LW'(0));
                  cnt_in   = cnt_next;
                  if (at_end) begin
                     pend_in.count = 7'(cnt_next);
                     state_in      = S_OUT;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_PRD;
                  end
               end else begin
                  if (div_rem == '0) begin
                     if (div_quot == {{(DVD_W-DVS_W){1'b0}}, dj_ff}) begin
                        sum_in = sum_ff + SUM_W'(dj_ff);
                     end else begin
                        sum_in = sum_ff + SUM_W'(dj_ff) + SUM_W'(div_quot);
                     end
                  end
                  dj_in        = dj_ff + 1'b1;
                  div_start_in = 1'b1;
               end
            end
         end
         S_MRD: begin
            state_in = S_MUSE;
         end
         S_MUSE: begin
            lo_c  = (idx_ff == '0) ? elem : lo_ff;
            sec_c = (idx_ff == '0) ? sal_pkg::NONE_MARK : sec_ff;
            if (elem < lo_c) begin
               sec_c = lo_c;
               lo_c  = elem;
            end else if (elem > lo_c && elem < sec_c) begin
               sec_c = elem;
            end
            lo_in  = lo_c;
            sec_in = sec_c;
            if (at_end) begin
               if (sec_c == sal_pkg::NONE_MARK) begin
                  pend_in.status = sal_pkg::ST_NOSECOND;
               end else begin
                  pend_in.data = sec_c;
               end
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_MRD;
            end
         end
         S_IRD: begin
            ram_raddr = AW'(idx_ff - 1'b1);
            if (idx_ff == '0) begin
               ram_we        = 1'b1;
               ram_waddr     = '0;
               ram_wdata     = key_ff;
               len_in        = len_ff + 1'b1;
               pend_in.count = 7'(len_ff + 1'b1);
               state_in      = S_OUT;
            end else begin
               state_in = S_IUSE;
            end
         end
         S_IUSE: begin
            ram_we   = 1'b1;
            idx_in   = idx_ff - 1'b1;
            state_in = S_IRD;
         end
         S_DRD: begin
            ram_raddr = AW'(idx_ff + 1'b1);
            if ((idx_ff + 1'b1) >= len_ff) begin
               len_in        = len_ff - 1'b1;
               pend_in.count = 7'(len_ff - 1'b1);
               state_in      = S_OUT;
            end else begin
               state_in = S_DUSE;
            end
         end
         S_DUSE: begin
            ram_we   = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = S_DRD;
         end
         S_SRDI: begin
            state_in = S_SUSEI;
         end
         S_SUSEI: begin
            cur_in   = elem;
            jdx_in   = idx_ff + 1'b1;
            state_in = S_SRDJ;
         end
         S_SRDJ: begin
            ram_raddr = jdx_ff[AW-1:0];
            state_in  = S_SUSEJ;
         end
         S_SUSEJ: begin
            // The running head of position i swaps with any larger element.
            if (cur_ff < elem) begin
               ram_we    = 1'b1;
               ram_waddr = jdx_ff[AW-1:0];
               ram_wdata = cur_ff;
               cur_in    = elem;
            end
            if ((jdx_ff + 1'b1) < len_ff) begin
               jdx_in   = jdx_ff + 1'b1;
               state_in = S_SRDJ;
            end else begin
               state_in = S_SWRI;
            end
         end
         S_SWRI: begin
            ram_we    = 1'b1;
            ram_wdata = cur_ff;
            if ((idx_ff + LW'(2)) < len_ff) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SRDI;
            end else begin
               idx_in   = '0;
               state_in = S_ORD;
            end
         end
         S_FRD: begin
            state_in = S_FUSE;
         end
         S_FUSE: begin
            if (elem == key_ff) begin
               pend_in.index = 6'(idx_ff);
               state_in      = S_OUT;
            end else if (at_end) begin
               pend_in.status = sal_pkg::ST_NOTFOUND;
               state_in       = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_FRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      jdx_ff       <= jdx_in;
      cnt_ff       <= cnt_in;
      key_ff       <= key_in;
      cur_ff       <= cur_in;
      lo_ff        <= lo_in;
      sec_ff       <= sec_in;
      n_ff         <= n_in;
      dj_ff        <= dj_in;
      sum_ff       <= sum_in;
      pend_ff      <= pend_in;
      pend_last_ff <= pend_last_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for small_array_list_engine: drives command words with
// bursty timing, predicts every result word from its own copy of the list and
// compares each returned word field by field, under random output stalls.
// ----------------------------------------------------------------------------
module tb;
   import sal_pkg::*;

   localparam int LIST_DEPTH  = 64;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      rsp_word_type word;
      bit           last;
   } list_rsp_type;

   class list_scoreboard;
      logic signed [31:0] elems[LIST_DEPTH];
      int unsigned        len;
      list_rsp_type       pending[$];
      int                 mismatches;
      int                 words_checked;

      function void push(logic signed [31:0] d, logic [5:0] idx, logic [6:0] cnt,
                         logic [2:0] st, bit last);
         list_rsp_type r;
         r.word.data   = d;
         r.word.index  = idx;
         r.word.count  = cnt;
         r.word.status = st;
         r.last        = last;
         pending.push_back(r);
      endfunction

      function bit is_perfect_value(logic signed [31:0] v);
         longint n, s, j, q;
         n = v;
         s = 1;
         if (n <= 1) return 0;
         for (j = 2; j * j <= n; j++) begin
            if (n % j == 0) begin
               q = n / j;
               s += j + ((q == j) ? 0 : q);
            end
         end
         return s == n;
      endfunction

      function void push_listing();
         if (len == 0) begin
            push(0, 0, 0, ST_OK, 1);
         end else begin
            for (int i = 0; i < len; i++)
               push(elems[i], i, len, ST_OK, i + 1 == len);
         end
      endfunction

      // Works out the result words caused by one accepted command word.
      function void note_command(logic [3:0] cmd, logic signed [31:0] v, logic [5:0] pos);
         logic signed [31:0] lo, second, t;
         int                 hits;
         bit                 found;
         case (cmd)
            CMD_CLEAR: begin
               len = 0;
               push(0, 0, 0, ST_OK, 1);
            end
            CMD_APPEND, CMD_INSERT: begin
               if (len >= LIST_DEPTH) begin
                  push(0, 0, len, ST_FULL, 1);
               end else begin
                  if (cmd == CMD_APPEND) begin
                     elems[len] = v;
                  end else begin
                     for (int i = len; i > 0; i--) elems[i] = elems[i - 1];
                     elems[0] = v;
                  end
                  len++;
                  push(0, 0, len, ST_OK, 1);
               end
            end
            CMD_READ: push_listing();
            CMD_PERFECT: begin
               hits = 0;
               for (int i = 0; i < len; i++) if (is_perfect_value(elems[i])) hits++;
               push(0, 0, hits, ST_OK, 1);
            end
            CMD_SECOND: begin
               if (len < 2) begin
                  push(0, 0, len, ST_UNDER2, 1);
               end else begin
                  lo = elems[0];
                  second = NONE_MARK;
                  for (int i = 0; i < len; i++) begin
                     if (elems[i] < lo) begin
                        second = lo;
                        lo = elems[i];
                     end else if (elems[i] > lo && elems[i] < second) begin
                        second = elems[i];
                     end
                  end
                  if (second == NONE_MARK) push(0, 0, len, ST_NOSECOND, 1);
                  else push(second, 0, len, ST_OK, 1);
               end
            end
            CMD_DELETE: begin
               if (pos >= len) begin
                  push(0, 0, len, ST_BADPOS, 1);
               end else begin
                  for (int i = pos; i + 1 < len; i++) elems[i] = elems[i + 1];
                  len--;
                  push(0, 0, len, ST_OK, 1);
               end
            end
            CMD_SORT: begin
               for (int i = 0; i + 1 < len; i++) begin
                  for (int j = i + 1; j < len; j++) begin
                     if (elems[i] < elems[j]) begin
                        t = elems[i];
                        elems[i] = elems[j];
                        elems[j] = t;
                     end
                  end
               end
               push_listing();
            end
            CMD_SEARCH: begin
               found = 0;
               for (int i = 0; i < len && !found; i++) begin
                  if (elems[i] == v) begin
                     push(0, i, len, ST_OK, 1);
                     found = 1;
                  end
               end
               if (!found) push(0, 0, len, ST_NOTFOUND, 1);
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [47:0] tdata, logic tlast);
         list_rsp_type exp_rsp;
         rsp_word_type got;
         got = tdata;
         words_checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result word %h last %b", tdata, tlast);
            return;
         end
         exp_rsp = pending.pop_front();
         if (got.data !== exp_rsp.word.data || got.index !== exp_rsp.word.index ||
             got.count !== exp_rsp.word.count || got.status !== exp_rsp.word.status ||
             tlast !== exp_rsp.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: expected data %0d index %0d count %0d status %0d last %0d, got data %0d index %0d count %0d status %0d last %0d",
                        exp_rsp.word.data, exp_rsp.word.index, exp_rsp.word.count,
                        exp_rsp.word.status, exp_rsp.last, got.data, got.index,
                        got.count, got.status, tlast);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   list_scoreboard sb = new();
   int  cycle_count = 0;
   int  burst_left = 0;
   int  cmd_seen[16];
   bit  start_hold = 0;

   small_array_list_engine #(.DEPTH(LIST_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("small_array_list_engine test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   // Output stall pattern, with one long hold-off on request.
   initial begin
      int hold_left, phase_left, stall_mode;
      hold_left = 0;
      phase_left = 0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 0;
            hold_left--;
         end else if (start_hold) begin
            start_hold = 0;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 0;
         end else begin
            if (phase_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            case (stall_mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Offers one word and waits for it to be taken; gaps come between bursts.
   task automatic send(logic [3:0] cmd, logic signed [31:0] v = 0, logic [5:0] pos = 0);
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, pos, v};
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, v, pos);
      cmd_seen[cmd]++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 7);
      end
   endtask

   function automatic logic signed [31:0] pick_value(bit narrow);
      if (!narrow) return $urandom;
      case ($urandom_range(0, 5))
         0: return -$signed({1'b0, 31'($urandom_range(0, 100))});
         1: return 6;
         2: return 28;
         default: return $urandom_range(0, 2000);
      endcase
   endfunction

   task automatic random_op(bit narrow);
      int c;
      c = $urandom_range(0, 19);
      if (c < 4) begin
         send(CMD_APPEND, pick_value(narrow));
      end else if (c < 6) begin
         send(CMD_INSERT, pick_value(narrow));
      end else if (c < 8) begin
         send(CMD_DELETE, 0, ($urandom_range(0, 3) == 0) ? 6'($urandom) :
                             6'($urandom_range(0, sb.len + 1)));
      end else if (c < 10) begin
         if (sb.len > 0 && $urandom_range(0, 1))
            send(CMD_SEARCH, sb.elems[$urandom_range(0, sb.len - 1)]);
         else
            send(CMD_SEARCH, pick_value(narrow));
      end else if (c < 12) begin
         send(CMD_SECOND);
      end else if (c < 14) begin
         send(CMD_READ);
      end else if (c < 15) begin
         send(CMD_SORT);
      end else if (c < 17) begin
         // Perfect count is slow on large values, so only narrow lists get it.
         send(narrow ? CMD_PERFECT : CMD_READ);
      end else if (c < 18) begin
         send(4'($urandom_range(9, 15)));
      end else if (c < 19) begin
         send(CMD_CLEAR);
      end else begin
         send(CMD_APPEND, pick_value(narrow));
      end
   endtask

   initial begin
      bit narrow;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: empty-list corners, perfect values, sentinel edges.
      send(CMD_READ);
      send(CMD_SORT);
      send(CMD_SECOND);
      send(CMD_SEARCH, 7);
      send(CMD_DELETE, 0, 0);
      send(CMD_APPEND, 6);
      send(CMD_SECOND);
      send(CMD_APPEND, 28);
      send(CMD_APPEND, 32'sh8000_0000);
      send(CMD_INSERT, NONE_MARK);
      send(CMD_APPEND, 1);
      send(CMD_APPEND, 0);
      send(CMD_APPEND, 8128);
      send(CMD_PERFECT);
      send(CMD_SECOND);
      send(CMD_SEARCH, 28);
      send(CMD_DELETE, 0, 2);
      send(CMD_SORT);
      send(CMD_CLEAR);
      send(CMD_APPEND, 5);
      send(CMD_APPEND, 5);
      send(CMD_SECOND);
      send(CMD_APPEND, NONE_MARK);
      send(CMD_SECOND);
      send(4'd15);

      // Full list: overflow on both append and insert, top index and position.
      send(CMD_CLEAR);
      for (int i = 0; i < LIST_DEPTH; i++) send(i[0] ? CMD_INSERT : CMD_APPEND, $urandom);
      send(CMD_APPEND, 3);
      send(CMD_INSERT, 3);
      send(CMD_SEARCH, sb.elems[LIST_DEPTH - 1]);
      send(CMD_SECOND);
      start_hold = 1;
      send(CMD_READ);
      send(CMD_DELETE, 0, 6'd63);
      send(CMD_SORT);
      send(CMD_DELETE, 0, 6'd63);

      // Random part: each segment rebuilds a list, then runs mixed commands.
      repeat (2) begin
         narrow = $urandom_range(0, 1);
         send(CMD_CLEAR);
         repeat ($urandom_range(1, 4)) send(CMD_APPEND, pick_value(narrow));
         repeat ($urandom_range(2, 4)) random_op(narrow);
      end

      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Covered %0d clears, %0d appends, %0d inserts, %0d deletes, %0d searches,",
               cmd_seen[CMD_CLEAR], cmd_seen[CMD_APPEND], cmd_seen[CMD_INSERT],
               cmd_seen[CMD_DELETE], cmd_seen[CMD_SEARCH]);
      $display("%0d reads, %0d sorts, %0d perfect counts, %0d second-min; %0d words checked",
               cmd_seen[CMD_READ], cmd_seen[CMD_SORT], cmd_seen[CMD_PERFECT],
               cmd_seen[CMD_SECOND], sb.words_checked);
      if (sb.mismatches == 0) begin
         $display("small_array_list_engine test passed");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("small_array_list_engine test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sal_pkg.sv
design/sal_ram.sv
design/sal_div.sv
design/small_array_list_engine.sv
tb/sv/tb.sv
